@@ hw/rtl/sfsg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfsg_pkg: shared types and constants for the freshness safety gate
// Transaction payloads, configuration block, stored sensor state and the
// reason codes that the gate reports.
// ----------------------------------------------------------------------------
package sfsg_pkg;

  // Tick counter width
  localparam int TIME_BITS = 48;
  // Comparison width for ages against 32-bit timeouts
  localparam int AGE_BITS  = (TIME_BITS > 32) ? TIME_BITS : 32;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_COMMAND_TIMEOUT      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SCAN_AGE_LIMIT       = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ODOMETRY_TIMEOUT     = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RAW_ODOMETRY_TIMEOUT = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_VOLT_FLOOR           = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_NEED_SCAN            = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_NEED_ODOMETRY        = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_NEED_RAW_ODOMETRY    = 3'd7;

  localparam logic [31:0] TIMEOUT_RESET = 32'd500;

  // Seen flag bit positions
  localparam int SEEN_CMD  = 0;
  localparam int SEEN_SCAN = 1;
  localparam int SEEN_ODOM = 2;
  localparam int SEEN_RAW  = 3;
  localparam int SEEN_VOLT = 4;

  typedef enum logic [3:0] {
    REASON_OK           = 4'd0,
    REASON_ESTOP        = 4'd1,
    REASON_CMD_INVALID  = 4'd2,
    REASON_CMD_MISSING  = 4'd3,
    REASON_CMD_STALE    = 4'd4,
    REASON_SCAN_MISSING = 4'd5,
    REASON_SCAN_STALE   = 4'd6,
    REASON_ODOM_MISSING = 4'd7,
    REASON_ODOM_STALE   = 4'd8,
    REASON_RAW_MISSING  = 4'd9,
    REASON_RAW_STALE    = 4'd10,
    REASON_VOLT_MISSING = 4'd11,
    REASON_VOLT_INVALID = 4'd12,
    REASON_VOLT_LOW     = 4'd13
  } reason_t;

  typedef struct packed {
    logic [47:0] current_time;
    logic        command_arrived;
    logic        command_rejected;
    logic        scan_arrived;
    logic        odometry_arrived;
    logic        raw_odometry_arrived;
    logic        voltage_arrived;
    logic [15:0] voltage_sample;
    logic        voltage_finite;
    logic        stop_write;
    logic        stop_level;
  } in_t;

  typedef struct packed {
    logic       allowed;
    logic [3:0] reason_code;
    logic       command_fresh;
  } out_t;

  typedef struct packed {
    logic [31:0] command_timeout;
    logic [31:0] scan_age_limit;
    logic [31:0] odometry_timeout;
    logic [31:0] raw_odometry_timeout;
    logic [15:0] volt_floor;
    logic        need_scan;
    logic        need_odometry;
    logic        need_raw_odometry;
  } cfg_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] command_time;
    logic [TIME_BITS-1:0] scan_time;
    logic [TIME_BITS-1:0] odometry_time;
    logic [TIME_BITS-1:0] raw_odometry_time;
    logic [4:0]           seen_flags;
    logic                 command_bad;
    logic                 stop_engaged;
    logic [15:0]          last_voltage;
    logic                 last_voltage_finite;
  } state_t;

endpackage

@@ hw/rtl/sfsg_eval.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfsg_eval: freshness checks and reason priority encoder
// Compares each stored arrival time against the item time and picks the
// first failing reason in fixed priority order.
// ----------------------------------------------------------------------------
module sfsg_eval (
  input  sfsg_pkg::state_t                 st,
  input  sfsg_pkg::cfg_t                   cfg,
  input  logic [sfsg_pkg::TIME_BITS-1:0]   now,
  output sfsg_pkg::out_t                   res
);

  logic cmd_ok;
  logic scan_ok;
  logic odom_ok;
  logic raw_ok;
  logic volt_check;
  sfsg_pkg::reason_t reason;

  // Fresh when the time did not go backwards and the age fits the timeout
  function automatic logic age_ok(
    input logic [sfsg_pkg::TIME_BITS-1:0] stamp,
    input logic [sfsg_pkg::TIME_BITS-1:0] t_now,
    input logic [31:0]                    limit
  );
    logic [sfsg_pkg::TIME_BITS:0]  diff;
    logic [sfsg_pkg::AGE_BITS-1:0] age;
    logic [sfsg_pkg::AGE_BITS-1:0] lim;
    diff = {1'b0, t_now} - {1'b0, stamp};
    age  = sfsg_pkg::AGE_BITS'(diff[sfsg_pkg::TIME_BITS-1:0]);
    lim  = sfsg_pkg::AGE_BITS'(limit);
    return !diff[sfsg_pkg::TIME_BITS] && (age <= lim);
  endfunction

  // Run the four age checks in parallel
  always_comb begin
    cmd_ok  = st.seen_flags[sfsg_pkg::SEEN_CMD] &&
              age_ok(st.command_time, now, cfg.command_timeout);
    scan_ok = age_ok(st.scan_time, now, cfg.scan_age_limit);
    odom_ok = age_ok(st.odometry_time, now, cfg.odometry_timeout);
    raw_ok  = age_ok(st.raw_odometry_time, now, cfg.raw_odometry_timeout);
    volt_check = (cfg.volt_floor != 16'd0);
  end

  // Pick the first failing reason
  always_comb begin
    if (st.stop_engaged) begin
      reason = sfsg_pkg::REASON_ESTOP;
    end else if (st.command_bad) begin
      reason = sfsg_pkg::REASON_CMD_INVALID;
    end else if (!st.seen_flags[sfsg_pkg::SEEN_CMD]) begin
      reason = sfsg_pkg::REASON_CMD_MISSING;
    end else if (!cmd_ok) begin
      reason = sfsg_pkg::REASON_CMD_STALE;
    end else if (cfg.need_scan && !st.seen_flags[sfsg_pkg::SEEN_SCAN]) begin
      reason = sfsg_pkg::REASON_SCAN_MISSING;
    end else if (cfg.need_scan && !scan_ok) begin
      reason = sfsg_pkg::REASON_SCAN_STALE;
    end else if (cfg.need_odometry && !st.seen_flags[sfsg_pkg::SEEN_ODOM]) begin
      reason = sfsg_pkg::REASON_ODOM_MISSING;
    end else if (cfg.need_odometry && !odom_ok) begin
      reason = sfsg_pkg::REASON_ODOM_STALE;
    end else if (cfg.need_raw_odometry && !st.seen_flags[sfsg_pkg::SEEN_RAW]) begin
      reason = sfsg_pkg::REASON_RAW_MISSING;
    end else if (cfg.need_raw_odometry && !raw_ok) begin
      reason = sfsg_pkg::REASON_RAW_STALE;
    end else if (volt_check && !st.seen_flags[sfsg_pkg::SEEN_VOLT]) begin
      reason = sfsg_pkg::REASON_VOLT_MISSING;
    end else if (volt_check && !st.last_voltage_finite) begin
      reason = sfsg_pkg::REASON_VOLT_INVALID;
    end else if (volt_check && (st.last_voltage < cfg.volt_floor)) begin
      reason = sfsg_pkg::REASON_VOLT_LOW;
    end else begin
      reason = sfsg_pkg::REASON_OK;
    end
  end

  assign res.allowed       = (reason == sfsg_pkg::REASON_OK);
  assign res.reason_code   = reason;
  assign res.command_fresh = cmd_ok;

endmodule

@@ hw/rtl/sensor_freshness_safety_gate_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_freshness_safety_gate_top: motion permission gate
// Tracks sensor arrival times, command validity, battery voltage and the
// emergency stop, and grants or denies motion for every tick transaction.
// ----------------------------------------------------------------------------
// The gate takes one transaction per clock cycle while in_ready is high and
// returns one result per transaction, in order. A transaction updates the stored
// sensor state and the evaluate time at the edge at which it is accepted; the
// evaluate stage then loads its result into the output register once that
// register is empty or being drained. The evaluate stage is four parallel 48-bit
// age subtract-and-compare checks feeding a priority encoder.
// A stalled output holds the evaluate stage, and input ready drops only while
// the evaluate stage and the output register are both full and the output
// side is not ready. Configuration registers are written through a plain
// write port and must only be written while the gate is idle.
module sensor_freshness_safety_gate_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  sfsg_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output sfsg_pkg::out_t                      out_data,
  input  logic                                cfg_write,
  input  logic [sfsg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [sfsg_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  sfsg_pkg::cfg_t   cfg;
  sfsg_pkg::state_t st;
  sfsg_pkg::state_t st_next;
  logic [sfsg_pkg::TIME_BITS-1:0] now;
  logic [sfsg_pkg::TIME_BITS-1:0] in_time;
  logic            eval_valid;
  logic            eval_advance;
  logic            in_accept;
  sfsg_pkg::out_t  eval_res;

  assign in_time      = sfsg_pkg::TIME_BITS'(in_data.current_time);
  assign eval_advance = eval_valid && (!out_valid || out_ready);
  assign in_ready     = !eval_valid || eval_advance;
  assign in_accept    = in_valid && in_ready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.command_timeout      <= sfsg_pkg::TIMEOUT_RESET;
      cfg.scan_age_limit       <= sfsg_pkg::TIMEOUT_RESET;
      cfg.odometry_timeout     <= sfsg_pkg::TIMEOUT_RESET;
      cfg.raw_odometry_timeout <= sfsg_pkg::TIMEOUT_RESET;
      cfg.volt_floor           <= 16'd0;
      cfg.need_scan            <= 1'b0;
      cfg.need_odometry        <= 1'b0;
      cfg.need_raw_odometry    <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        sfsg_pkg::CFG_COMMAND_TIMEOUT:      cfg.command_timeout      <= cfg_data;
        sfsg_pkg::CFG_SCAN_AGE_LIMIT:       cfg.scan_age_limit       <= cfg_data;
        sfsg_pkg::CFG_ODOMETRY_TIMEOUT:     cfg.odometry_timeout     <= cfg_data;
        sfsg_pkg::CFG_RAW_ODOMETRY_TIMEOUT: cfg.raw_odometry_timeout <= cfg_data;
        sfsg_pkg::CFG_VOLT_FLOOR:           cfg.volt_floor           <= cfg_data[15:0];
        sfsg_pkg::CFG_NEED_SCAN:            cfg.need_scan            <= cfg_data[0];
        sfsg_pkg::CFG_NEED_ODOMETRY:        cfg.need_odometry        <= cfg_data[0];
        sfsg_pkg::CFG_NEED_RAW_ODOMETRY:    cfg.need_raw_odometry    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Apply the arrival strobes of an accepted transaction
  always_comb begin
    st_next = st;
    if (in_data.command_arrived) begin
      st_next.command_time                   = in_time;
      st_next.seen_flags[sfsg_pkg::SEEN_CMD] = 1'b1;
      st_next.command_bad                    = 1'b0;
    end
    // Invalid strobe wins over a command arrival
    if (in_data.command_rejected) begin
      st_next.command_bad = 1'b1;
    end
    if (in_data.scan_arrived) begin
      st_next.scan_time                       = in_time;
      st_next.seen_flags[sfsg_pkg::SEEN_SCAN] = 1'b1;
    end
    if (in_data.odometry_arrived) begin
      st_next.odometry_time                   = in_time;
      st_next.seen_flags[sfsg_pkg::SEEN_ODOM] = 1'b1;
    end
    if (in_data.raw_odometry_arrived) begin
      st_next.raw_odometry_time              = in_time;
      st_next.seen_flags[sfsg_pkg::SEEN_RAW] = 1'b1;
    end
    if (in_data.voltage_arrived) begin
      st_next.last_voltage                    = in_data.voltage_sample;
      st_next.last_voltage_finite             = in_data.voltage_finite;
      st_next.seen_flags[sfsg_pkg::SEEN_VOLT] = 1'b1;
    end
    if (in_data.stop_write) begin
      st_next.stop_engaged = in_data.stop_level;
    end
  end

  // Hold stored sensor state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (in_accept) begin
      st <= st_next;
    end
  end

  // Advance the evaluate stage
  always_ff @(posedge clk) begin
    if (rst) begin
      eval_valid <= 1'b0;
    end else if (in_ready) begin
      eval_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      now <= in_time;
    end
  end

  sfsg_eval u_eval (
    .st  (st),
    .cfg (cfg),
    .now (now),
    .res (eval_res)
  );

  // Load the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (eval_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eval_advance) begin
      out_data <= eval_res;
    end
  end

  // Checks
  a_allowed_matches_reason: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.allowed == (out_data.reason_code == sfsg_pkg::REASON_OK)))
    else $error("allowed disagrees with reason code");

  a_allowed_needs_fresh: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.allowed) |-> out_data.command_fresh)
    else $error("motion allowed without a fresh command");

  a_reject_sets_bad: assert property (@(posedge clk) disable iff (rst)
    (in_accept && in_data.command_rejected) |=> st.command_bad)
    else $error("rejected command did not mark command bad");

  a_stop_engages: assert property (@(posedge clk) disable iff (rst)
    (in_accept && in_data.stop_write && in_data.stop_level) |=> st.stop_engaged)
    else $error("stop write did not engage the stop");

  a_stall_holds_eval: assert property (@(posedge clk) disable iff (rst)
    (eval_valid && out_valid && !out_ready) |=> (eval_valid && $stable(now)))
    else $error("evaluate stage lost a transaction under stall");

endmodule
